>>> rtl/core/lgpe_pkg.sv
// ----------------------------------------------------------------------------
// lgpe_pkg
// Shared widths, command codes and controller/datapath link types for the
// log-Gabor row phase encoder.
// ----------------------------------------------------------------------------
package lgpe_pkg;

  // field widths of the stream items
  localparam int unsigned CmdW   = 2;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CoefW  = 24;
  localparam int unsigned PixW   = 8;
  localparam int unsigned LimitW = 39;

  // stream bus widths, fields packed from bit 0 and padded to whole bytes
  localparam int unsigned STDataW = 48;
  localparam int unsigned MTDataW = 16;

  // input field positions in s_axis_tdata
  localparam int unsigned IdxLo  = 0;
  localparam int unsigned CoefLo = IdxLo + IdxW;
  localparam int unsigned PixLo  = CoefLo + CoefW;
  localparam int unsigned MaskLo = PixLo + PixW;

  // request command codes
  localparam logic [CmdW-1:0] CMD_LOAD_TAP = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD_PIX = 2'd1;
  localparam logic [CmdW-1:0] CMD_COMPUTE  = 2'd2;

  // reset value of the near-zero limit
  localparam logic [LimitW-1:0] LIMIT_RESET = 39'd1;

  // controller to datapath commands
  typedef struct packed {
    logic wr_tap;    // write kernel tap from the accepted request
    logic wr_pix;    // write pixel and mask from the accepted request
    logic start;     // capture column, clear accumulator and step counter
    logic rd_mask;   // read row store at the captured column
    logic cap_mask;  // latch the mask bit of the captured column
    logic issue;     // issue one tap and pixel read, advance the step
    logic calc_mag;  // register magnitude and sign of the sum
    logic finish;    // load the output register
  } lgpe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_ok;     // index of the offered request lies inside the row
    logic last_step;  // the step counter is at the last tap
    logic out_free;   // the output register can take a result this cycle
  } lgpe_stat_t;

endpackage

>>> rtl/core/lgpe_ctrl.sv
// ----------------------------------------------------------------------------
// lgpe_ctrl
// Sequencer for the encoder: accepts requests, dispatches loads, and walks a
// compute request through mask read, tap sweep, pipeline drain and result.
// ----------------------------------------------------------------------------
module lgpe_ctrl
  import lgpe_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic [CmdW-1:0] s_cmd_i,
  output logic            s_ready_o,
  input  lgpe_stat_t      stat_i,
  output lgpe_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MASK,
    ST_MCAP,
    ST_RUN,
    ST_DRAIN,
    ST_MAG,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   rdy_q;
  logic   drain_q;
  logic   accept;

  assign accept    = s_valid_i && rdy_q;
  assign s_ready_o = rdy_q;

  // command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.idx_ok) begin
          cmd_o.wr_tap = (s_cmd_i == CMD_LOAD_TAP);
          cmd_o.wr_pix = (s_cmd_i == CMD_LOAD_PIX);
          cmd_o.start  = (s_cmd_i == CMD_COMPUTE);
        end
      end
      ST_MASK:  cmd_o.rd_mask  = 1'b1;
      ST_MCAP:  cmd_o.cap_mask = 1'b1;
      ST_RUN:   cmd_o.issue    = 1'b1;
      ST_MAG:   cmd_o.calc_mag = 1'b1;
      ST_FIN:   cmd_o.finish   = stat_i.out_free;
      default: ;
    endcase
  end

  // state and ready register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
      drain_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && stat_i.idx_ok && s_cmd_i == CMD_COMPUTE) begin
            state_q <= ST_MASK;
            rdy_q   <= 1'b0;
          end
        end
        ST_MASK: state_q <= ST_MCAP;
        ST_MCAP: state_q <= ST_RUN;
        ST_RUN: begin
          if (stat_i.last_step) begin
            state_q <= ST_DRAIN;
            drain_q <= 1'b0;
          end
        end
        ST_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            state_q <= ST_MAG;
          end
        end
        ST_MAG: state_q <= ST_FIN;
        ST_FIN: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/lgpe_dp.sv
// ----------------------------------------------------------------------------
// lgpe_dp
// Datapath of the encoder: kernel and row stores, mirrored address
// generation, multiply-accumulate pipeline, limit register and output
// register.
// ----------------------------------------------------------------------------
module lgpe_dp
  import lgpe_pkg::*;
#(
  parameter int unsigned ROW_LEN  = 256,
  parameter int unsigned TAP_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STDataW-1:0] s_data_i,
  input  logic               cfg_we_i,
  input  logic [LimitW-1:0]  cfg_wdata_i,
  input  logic               m_ready_i,
  output logic               m_valid_o,
  output logic [MTDataW-1:0] m_data_o,
  input  lgpe_cmd_t          cmd_i,
  output lgpe_stat_t         stat_o
);

  localparam int unsigned AW     = $clog2(ROW_LEN);
  localparam int unsigned PW     = AW + 2;
  localparam int unsigned ProdW  = TAP_BITS + PixW + 1;
  localparam int unsigned AccW   = ProdW + AW;
  localparam int unsigned CmpW   = (AccW > LimitW) ? AccW : LimitW;
  localparam logic signed [PW-1:0] Half    = PW'(ROW_LEN / 2);
  localparam logic signed [PW-1:0] RowLenS = PW'(ROW_LEN);
  localparam logic signed [PW-1:0] TwoRm2  = PW'(2 * ROW_LEN - 2);
  localparam logic [AW-1:0]        LastJ   = AW'(ROW_LEN - 1);

  // request fields
  logic        [IdxW-1:0]     in_idx;
  logic signed [CoefW-1:0]    in_coef;
  logic        [PixW-1:0]     in_pix;
  logic                       in_mask;
  logic        [AW-1:0]       in_addr;
  logic signed [TAP_BITS-1:0] tap_wdata;

  assign in_idx    = s_data_i[IdxLo +: IdxW];
  assign in_coef   = $signed(s_data_i[CoefLo +: CoefW]);
  assign in_pix    = s_data_i[PixLo +: PixW];
  assign in_mask   = s_data_i[MaskLo];
  assign in_addr   = AW'(in_idx);
  assign tap_wdata = TAP_BITS'(in_coef);

  // stores
  logic signed [TAP_BITS-1:0] tap_mem [ROW_LEN];
  logic        [PixW:0]       pix_mem [ROW_LEN];
  logic signed [TAP_BITS-1:0] tap_rd_q;
  logic        [PixW:0]       pix_rd_q;

  // sweep control
  logic [IdxW-1:0] idx_q;
  logic [AW-1:0]   col_addr;
  logic [AW-1:0]   j_q;
  logic            mask_q;
  logic            v1_q;
  logic            v2_q;

  assign col_addr = AW'(idx_q);

  // mirror-101 position of the current step
  logic signed [PW-1:0] pos;
  logic signed [PW-1:0] refl;
  logic        [AW-1:0] tap_raddr;
  logic        [AW-1:0] pix_raddr;

  always_comb begin
    pos = $signed({2'b00, col_addr}) + $signed({2'b00, j_q}) - Half;
    if (pos < 0) begin
      refl = -pos;
    end else if (pos >= RowLenS) begin
      refl = TwoRm2 - pos;
    end else begin
      refl = pos;
    end
    tap_raddr = LastJ - j_q;
    pix_raddr = cmd_i.rd_mask ? col_addr : refl[AW-1:0];
  end

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tap) begin
      tap_mem[in_addr] <= tap_wdata;
    end
    if (cmd_i.wr_pix) begin
      pix_mem[in_addr] <= {in_mask, in_pix};
    end
    tap_rd_q <= tap_mem[tap_raddr];
    pix_rd_q <= pix_mem[pix_raddr];
  end

  // step counter and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        j_q <= '0;
      end else if (cmd_i.issue) begin
        j_q <= j_q + AW'(1);
      end
    end
  end

  // multiply and accumulate
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic        [AccW-1:0]  mag_q;
  logic                    gtz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q <= in_idx;
    end
    if (cmd_i.cap_mask) begin
      mask_q <= pix_rd_q[PixW];
    end
    prod_q <= ProdW'(tap_rd_q) * ProdW'($signed({1'b0, pix_rd_q[PixW-1:0]}));
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (cmd_i.calc_mag) begin
      mag_q <= acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
      gtz_q <= !acc_q[AccW-1] && (|acc_q);
    end
  end

  // near-zero limit register
  logic [LimitW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // output register
  logic            m_valid_q;
  logic            code_q;
  logic            valid_bit_q;
  logic [IdxW-1:0] column_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      code_q      <= gtz_q;
      valid_bit_q <= mask_q && (CmpW'(mag_q) >= CmpW'(limit_q));
      column_q    <= idx_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = {{(MTDataW - IdxW - 2){1'b0}}, column_q, valid_bit_q, code_q};

  // status
  assign stat_o.idx_ok    = (int'(in_idx) < int'(ROW_LEN));
  assign stat_o.last_step = (j_q == LastJ);
  assign stat_o.out_free  = !m_valid_q || m_ready_i;

endmodule

>>> rtl/core/log_gabor_row_phase_encoder.sv
// ----------------------------------------------------------------------------
// log_gabor_row_phase_encoder
// Convolves a stored texture row with a stored log-Gabor kernel at one
// column per compute request and returns the phase code bit and valid bit.
//
//   channel   dir  signals                         fields (low bit up)
//   s_axis    in   tvalid tready tdata tuser       tdata: index, coefficient,
//                                                  pixel, mask_bit; tuser: command
//   m_axis    out  tvalid tready tdata             tdata: code_bit, valid_bit,
//                                                  column
//   cfg       in   cfg_we_i cfg_wdata_i            near_zero_limit
//
// Load requests are accepted back to back. A compute request sweeps the
// row with the single multiply-accumulate unit that reads one tap and one
// pixel per cycle from the two stores; no request is taken until it is done.
// Reset clears control and sets the limit to 1; the stores are not cleared.
// The result waits in the output register while loads go on; a further
// compute holds at its last cycle until that register is free.
// ----------------------------------------------------------------------------
module log_gabor_row_phase_encoder
  import lgpe_pkg::*;
#(
  parameter int unsigned ROW_LEN  = 256,
  parameter int unsigned TAP_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [STDataW-1:0] s_axis_tdata,   // index, coefficient, pixel, mask_bit
  input  logic [CmdW-1:0]    s_axis_tuser,   // command
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MTDataW-1:0] m_axis_tdata,   // code_bit, valid_bit, column
  input  logic               cfg_we_i,
  input  logic [LimitW-1:0]  cfg_wdata_i
);

  lgpe_cmd_t  cmd;
  lgpe_stat_t stat;

  // sequencer
  lgpe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_cmd_i   (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // stores and multiply-accumulate
  lgpe_dp #(
    .ROW_LEN  (ROW_LEN),
    .TAP_BITS (TAP_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_data_i    (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
